[sv/pulse_duration_classifier_assert.svh]
// Assertion macros shared by the pulse duration classifier modules.
// Depends on nothing; included by the controller and the datapath.
`ifndef PULSE_DURATION_CLASSIFIER_ASSERT_SVH
`define PULSE_DURATION_CLASSIFIER_ASSERT_SVH

// ante holds in a cycle -> cons holds in the same cycle
`define PDC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pdc assertion failed");

// ante holds in a cycle -> cons holds in the next cycle
`define PDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pdc assertion failed");

`endif

[sv/pdc_pkg.sv]
// Package for the pulse duration classifier: sizes, codes, types, helpers.
// No dependencies.
package pdc_pkg;

  localparam int MAX_ENTRIES = 4;
  localparam int DUR_W       = 16;
  localparam int MAG_W       = 15;
  localparam int TOL_W       = 15;
  localparam int OIDX_W      = 2;
  localparam int OCNT_W      = 3;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int TIDX_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(50);

  localparam logic [1:0] MODE_CLASSIFY = 2'd0;
  localparam logic [1:0] MODE_APPEND   = 2'd1;
  localparam logic [1:0] MODE_CLEAR    = 2'd2;

  typedef enum logic [2:0] {
    ST_MATCH    = 3'd0,
    ST_CLOSEST  = 3'd1,
    ST_NOMATCH  = 3'd2,
    ST_APPENDED = 3'd3,
    ST_REFUSED  = 3'd4,
    ST_CLEARED  = 3'd5
  } status_t;

  typedef logic [DUR_W-1:0]  dur_t;
  typedef logic [MAG_W-1:0]  mag_t;
  typedef logic [MAG_W:0]    diff_t;
  typedef logic [TOL_W-1:0]  tol_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [TIDX_W-1:0] tidx_t;
  typedef logic [OIDX_W-1:0] oidx_t;
  typedef logic [OCNT_W-1:0] ocnt_t;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic start_classify;
    logic scan_end;
    logic out_free;
  } dp_status_t;

  // magnitude of a signed duration; the most negative value saturates
  function automatic mag_t abs_sat(input dur_t d);
    dur_t neg;
    neg = dur_t'(~d + dur_t'(1));
    if (!d[DUR_W-1]) begin
      return mag_t'(d);
    end else if (neg[DUR_W-1]) begin
      return {MAG_W{1'b1}};
    end else begin
      return mag_t'(neg);
    end
  endfunction

endpackage

[sv/pdc_if.sv]
// Channel interfaces of the pulse duration classifier.
// Depends on pdc_pkg.
interface pdc_in_if;
  logic          valid;
  logic          ready;
  logic [1:0]    mode;
  pdc_pkg::dur_t duration;

  modport source (output valid, output mode, output duration, input ready);
  modport sink (input valid, input mode, input duration, output ready);
endinterface

interface pdc_out_if;
  logic            valid;
  logic            ready;
  pdc_pkg::status_t status;
  pdc_pkg::oidx_t   entry_index;
  pdc_pkg::ocnt_t   entries_used;

  modport source (output valid, output status, output entry_index, output entries_used,
                  input ready);
  modport sink (input valid, input status, input entry_index, input entries_used,
                output ready);
endinterface

[sv/pdc_ctrl.sv]
// Controller of the pulse duration classifier: accept, scan, emit sequencing.
// Depends on pdc_pkg and pulse_duration_classifier_assert.svh.
`include "pulse_duration_classifier_assert.svh"

module pdc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                pulse_valid,
  output logic                pulse_ready,
  input  pdc_pkg::dp_status_t stat,
  output pdc_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    pulse_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        pulse_ready = 1'b1;
        if (pulse_valid) begin
          cmd.load   = 1'b1;
          state_next = stat.start_classify ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (stat.scan_end) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `PDC_ASSERT_SAME(a_cmd_exclusive, clk, rst, 1'b1, $onehot0({cmd.load, cmd.step, cmd.emit}))
  `PDC_ASSERT_NEXT(a_emit_returns_idle, clk, rst, cmd.emit, pulse_ready)
  `PDC_ASSERT_SAME(a_emit_needs_room, clk, rst, cmd.emit, stat.out_free)

endmodule

[sv/pdc_datapath.sv]
// Datapath of the pulse duration classifier: table, count, scan and result register.
// Depends on pdc_pkg, pdc_if and pulse_duration_classifier_assert.svh.
`include "pulse_duration_classifier_assert.svh"

module pdc_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  pdc_pkg::tol_t      cfg_data,
  input  logic [1:0]         mode,
  input  pdc_pkg::dur_t      duration,
  input  pdc_pkg::ctrl_cmd_t cmd,
  output pdc_pkg::dp_status_t stat,
  pdc_out_if.source          result
);

  pdc_pkg::mag_t  ref_table [pdc_pkg::MAX_ENTRIES];
  pdc_pkg::tol_t  tol;
  pdc_pkg::cnt_t  count;
  pdc_pkg::cnt_t  count_next;
  logic [1:0]     mode_q;
  pdc_pkg::mag_t  mag_q;
  pdc_pkg::cnt_t  idx;
  logic           hit_q;
  pdc_pkg::tidx_t hit_idx;
  pdc_pkg::diff_t best_diff;
  pdc_pkg::tidx_t best_idx;
  logic           out_valid;

  pdc_pkg::tidx_t   rd_idx;
  pdc_pkg::mag_t    ref_val;
  pdc_pkg::mag_t    diff;
  logic             in_range;
  logic             diff_hit;
  logic             full;
  logic             table_we;
  pdc_pkg::status_t res_status;
  pdc_pkg::oidx_t   res_idx;

  assign rd_idx   = pdc_pkg::tidx_t'(idx);
  assign in_range = idx < count;
  assign ref_val  = ref_table[rd_idx];
  assign diff     = (ref_val >= mag_q) ? pdc_pkg::mag_t'(ref_val - mag_q)
                                       : pdc_pkg::mag_t'(mag_q - ref_val);
  assign diff_hit = in_range && (diff <= tol);
  assign full     = count >= pdc_pkg::cnt_t'(pdc_pkg::MAX_ENTRIES);

  assign stat.start_classify = (mode != pdc_pkg::MODE_APPEND) && (mode != pdc_pkg::MODE_CLEAR);
  assign stat.scan_end       = diff_hit || ((idx + pdc_pkg::cnt_t'(1)) >= count);
  assign stat.out_free       = !out_valid || result.ready;

  always_comb begin
    count_next = count;
    table_we   = 1'b0;
    res_status = pdc_pkg::ST_NOMATCH;
    res_idx    = '0;
    priority if (mode_q == pdc_pkg::MODE_CLEAR) begin
      count_next = '0;
      res_status = pdc_pkg::ST_CLEARED;
    end else if (mode_q == pdc_pkg::MODE_APPEND) begin
      if (full) begin
        res_status = pdc_pkg::ST_REFUSED;
      end else begin
        table_we   = 1'b1;
        count_next = count + pdc_pkg::cnt_t'(1);
        res_status = pdc_pkg::ST_APPENDED;
        res_idx    = pdc_pkg::oidx_t'(count);
      end
    end else if (hit_q) begin
      res_status = pdc_pkg::ST_MATCH;
      res_idx    = pdc_pkg::oidx_t'(hit_idx);
    end else if (full) begin
      res_status = pdc_pkg::ST_CLOSEST;
      res_idx    = pdc_pkg::oidx_t'(best_idx);
    end else begin
      res_status = pdc_pkg::ST_NOMATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tol       <= pdc_pkg::TOL_RESET;
      count     <= '0;
      out_valid <= 1'b0;
      hit_q     <= 1'b0;
      mode_q    <= pdc_pkg::MODE_CLASSIFY;
    end else begin
      if (cfg_write) begin
        tol <= cfg_data;
      end
      if (cmd.load) begin
        mode_q <= mode;
        hit_q  <= 1'b0;
      end else if (cmd.step && diff_hit) begin
        hit_q <= 1'b1;
      end
      if (cmd.emit) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_q     <= pdc_pkg::abs_sat(duration);
      idx       <= '0;
      best_diff <= '1;
      best_idx  <= '0;
    end else if (cmd.step) begin
      idx <= idx + pdc_pkg::cnt_t'(1);
      if (diff_hit) begin
        hit_idx <= rd_idx;
      end else if (in_range && ({1'b0, diff} < best_diff)) begin
        best_diff <= {1'b0, diff};
        best_idx  <= rd_idx;
      end
    end
    if (cmd.emit && table_we) begin
      ref_table[pdc_pkg::tidx_t'(count)] <= mag_q;
    end
    if (cmd.emit) begin
      result.status       <= res_status;
      result.entry_index  <= res_idx;
      result.entries_used <= pdc_pkg::ocnt_t'(count_next);
    end
  end

  assign result.valid = out_valid;

  `PDC_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= pdc_pkg::cnt_t'(pdc_pkg::MAX_ENTRIES))
  `PDC_ASSERT_NEXT(a_clear_empties, clk, rst, cmd.emit && (mode_q == pdc_pkg::MODE_CLEAR), count == '0)
  `PDC_ASSERT_SAME(a_hit_in_table, clk, rst, hit_q, pdc_pkg::cnt_t'(hit_idx) < count)
  `PDC_ASSERT_NEXT(a_emit_shows_result, clk, rst, cmd.emit, out_valid)

endmodule

[sv/pulse_duration_classifier.sv]
// Top level of the pulse duration classifier: controller plus datapath.
// Depends on pdc_pkg, pdc_if, pdc_ctrl and pdc_datapath.
//
//   channel  dir   handshake    payload
//   pulse    in    valid/ready  mode[1:0], duration[15:0] signed
//   result   out   valid/ready  status[2:0], entry_index[1:0], entries_used[2:0]
//   cfg      in    cfg_write    cfg_data[14:0] (match tolerance)
//
// Append and clear go from accept straight to finish, where the emit waits for room.
// Classify passes through a scan state first, which checks the entries up to the first match,
// one per cycle through the single table read port and compare unit.
// The result register loads on the clock edge at which the emit is given.
// Reset empties the table and sets the tolerance to 50; entry contents are not cleared.
// A waiting result does not block the next accept; only its emit waits for room.
module pulse_duration_classifier (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  pdc_pkg::tol_t cfg_data,
  pdc_in_if.sink        pulse,
  pdc_out_if.source     result
);

  pdc_pkg::ctrl_cmd_t  cmd;
  pdc_pkg::dp_status_t stat;
  logic                pulse_ready;

  assign pulse.ready = pulse_ready;

  pdc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pulse_valid (pulse.valid),
    .pulse_ready (pulse_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  pdc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .mode      (pulse.mode),
    .duration  (pulse.duration),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

endmodule

[test/pulse_duration_classifier_tb.sv]
// Self-checking testbench for pulse_duration_classifier: directed and random
// classify/append/clear traffic under random stalls, checked by a scoreboard.
// Depends on pdc_pkg, pdc_if and the pulse_duration_classifier RTL.
module pulse_duration_classifier_tb;
  import pdc_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_ITEMS  = 210;

  typedef struct packed {
    status_t status;
    oidx_t   entry_index;
    ocnt_t   entries_used;
  } outcome_t;

  class duration_table_book;
    mag_t       entry_mag[MAX_ENTRIES];
    int         used;
    tol_t       tolerance;
    outcome_t   pending_q[$];
    int         mismatches;

    function new();
      used = 0;
      tolerance = TOL_RESET;
      mismatches = 0;
    endfunction

    function mag_t magnitude(dur_t d);
      dur_t n;
      n = -d;
      if (d == 16'h8000) begin
        return {MAG_W{1'b1}};
      end else if (d[DUR_W-1]) begin
        return n[MAG_W-1:0];
      end else begin
        return d[MAG_W-1:0];
      end
    endfunction

    function void take_pulse(logic [1:0] mode, dur_t d);
      outcome_t o;
      mag_t     m;
      int       diff;
      int       best_diff;
      int       best_idx;
      bit       hit;
      m = magnitude(d);
      o.entry_index = '0;
      case (mode)
        MODE_CLEAR: begin
          used = 0;
          o.status = ST_CLEARED;
        end
        MODE_APPEND: begin
          if (used >= MAX_ENTRIES) begin
            o.status = ST_REFUSED;
          end else begin
            entry_mag[used] = m;
            o.status = ST_APPENDED;
            o.entry_index = oidx_t'(used);
            used++;
          end
        end
        default: begin
          hit = 0;
          best_diff = 1000000;
          best_idx = 0;
          for (int k = 0; k < used && !hit; k++) begin
            diff = int'(entry_mag[k]) - int'(m);
            if (diff < 0) diff = -diff;
            if (diff <= int'(tolerance)) begin
              hit = 1;
              o.status = ST_MATCH;
              o.entry_index = oidx_t'(k);
            end else if (diff < best_diff) begin
              best_diff = diff;
              best_idx = k;
            end
          end
          if (!hit) begin
            if (used < MAX_ENTRIES) begin
              o.status = ST_NOMATCH;
            end else begin
              o.status = ST_CLOSEST;
              o.entry_index = oidx_t'(best_idx);
            end
          end
        end
      endcase
      o.entries_used = ocnt_t'(used);
      pending_q = {pending_q, o};
    endfunction

    function void check_outcome(logic [2:0] status, oidx_t idx, ocnt_t cnt);
      outcome_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status=%0d index=%0d used=%0d", status, idx, cnt);
        return;
      end
      e = pending_q.pop_front();
      if (status !== e.status || idx !== e.entry_index || cnt !== e.entries_used) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: exp status=%0d index=%0d used=%0d, got %0d %0d %0d",
                   e.status, e.entry_index, e.entries_used, status, idx, cnt);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_write;
  tol_t cfg_data;
  int   cycle_count = 0;
  int   sent_count;
  int   seen_count;

  pdc_in_if  pulse_ch ();
  pdc_out_if result_ch ();

  duration_table_book book = new();

  pulse_duration_classifier dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .pulse     (pulse_ch),
    .result    (result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("pulse_duration_classifier verification failed");
      $finish;
    end
  end

  // runs of back-to-back transactions between randomly idling stretches
  function automatic int pick_gap(int seq);
    if ((seq / 50) % 3 == 0) return 0;
    return $urandom_range(0, 15);
  endfunction

  task automatic send_pulse(logic [1:0] mode, dur_t d);
    int gap;
    gap = pick_gap(sent_count);
    if (gap > 0) begin
      pulse_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pulse_ch.valid    <= 1'b1;
    pulse_ch.mode     <= mode;
    pulse_ch.duration <= d;
    do @(posedge clk); while (!pulse_ch.ready);
    book.take_pulse(mode, d);
    sent_count++;
  endtask

  task automatic write_tolerance(tol_t v);
    while (book.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    book.tolerance = v;
  endtask

  function automatic dur_t signed_pulse(int mag);
    if (mag < 0) mag = 0;
    if (mag > 32767) mag = 32767;
    if ($urandom_range(0, 1)) begin
      if (mag == 32767 && $urandom_range(0, 1)) return 16'h8000;
      return dur_t'(-mag);
    end
    return dur_t'(mag);
  endfunction

  task automatic make_pulse(output logic [1:0] mode, output dur_t d);
    int pick;
    int span;
    int base;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      mode = MODE_CLEAR;
      d = dur_t'($urandom);
    end else if (pick < 28) begin
      mode = MODE_APPEND;
      if ($urandom_range(0, 1)) d = signed_pulse($urandom_range(0, 40) * 100);
      else d = dur_t'($urandom);
    end else begin
      mode = (pick < 35) ? MODE_SPARE : MODE_CLASSIFY;
      if (book.used > 0 && $urandom_range(0, 9) < 6) begin
        base = int'(book.entry_mag[$urandom_range(0, book.used - 1)]);
        span = int'(book.tolerance) + 40;
        if (span > 2000) span = 2000;
        d = signed_pulse(base + $urandom_range(0, 2 * span) - span);
      end else if ($urandom_range(0, 3) == 0) begin
        d = signed_pulse($urandom_range(0, 80) * 50);
      end else begin
        d = dur_t'($urandom);
      end
    end
  endtask

  initial begin
    logic [1:0] m;
    dur_t       d;
    tol_t       tol_list[7];
    rst               <= 1'b1;
    cfg_write         <= 1'b0;
    cfg_data          <= '0;
    pulse_ch.valid    <= 1'b0;
    pulse_ch.mode     <= MODE_CLASSIFY;
    pulse_ch.duration <= '0;
    sent_count = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, saturated magnitude, spare mode, full table, tie, clear
    send_pulse(MODE_CLASSIFY, 16'sd100);
    send_pulse(MODE_APPEND, 16'h8000);
    send_pulse(MODE_CLASSIFY, 16'sd32767);
    send_pulse(MODE_APPEND, 16'sd0);
    send_pulse(MODE_CLASSIFY, -16'sd30);
    send_pulse(MODE_SPARE, 16'sd1000);
    send_pulse(MODE_APPEND, 16'sd1000);
    send_pulse(MODE_APPEND, -16'sd2000);
    send_pulse(MODE_APPEND, 16'sd5);
    send_pulse(MODE_CLASSIFY, 16'sd1500);
    send_pulse(MODE_CLASSIFY, 16'h8000);
    send_pulse(MODE_CLASSIFY, 16'sd16000);
    send_pulse(MODE_CLASSIFY, 16'sd1050);
    send_pulse(MODE_CLASSIFY, -16'sd1051);
    send_pulse(MODE_SPARE, 16'hFFFF);
    send_pulse(MODE_CLEAR, 16'h7FFF);
    send_pulse(MODE_CLASSIFY, 16'sd0);
    send_pulse(MODE_APPEND, 16'h7FFF);
    send_pulse(MODE_APPEND, 16'hFFFF);
    send_pulse(MODE_CLASSIFY, 16'sd52);
    send_pulse(MODE_CLEAR, 16'sd0);
    pulse_ch.valid <= 1'b0;

    tol_list = '{tol_t'(0), tol_t'(32767), tol_t'(50), tol_t'($urandom_range(0, 32767)),
                 tol_t'(1), tol_t'($urandom_range(0, 600)), tol_t'(400)};
    foreach (tol_list[p]) begin
      write_tolerance(tol_list[p]);
      repeat (PHASE_ITEMS) begin
        make_pulse(m, d);
        send_pulse(m, d);
      end
      pulse_ch.valid <= 1'b0;
    end

    while (book.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.mismatches == 0) begin
      $display("pulse_duration_classifier verification clean");
    end else begin
      $display("pulse_duration_classifier verification failed");
    end
    $finish;
  end

  initial begin
    int stall;
    result_ch.ready <= 1'b0;
    seen_count = 0;
    do @(posedge clk); while (rst);
    forever begin
      stall = pick_gap(seen_count + 25);
      if (seen_count == HOLD_AT) stall = HOLD_CYCLES;
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      book.check_outcome(result_ch.status, result_ch.entry_index, result_ch.entries_used);
      seen_count++;
    end
  end

endmodule
